// ===== rtl/playfair_encrypt_assert.svh =====
// Assertion macros used by the playfair encrypt checker.
`ifndef PLAYFAIR_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_ENCRYPT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("playfair_encrypt: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("playfair_encrypt: same-cycle check failed");

`endif

// ===== rtl/pfe_pkg.sv =====
// Types, constants, microcode program and helper functions of the playfair encrypt block.
`default_nettype none
package pfe_pkg;

	localparam logic [4:0] CELLS     = 5'd25;
	localparam logic [4:0] IDX_Q     = 5'd16;
	localparam logic [4:0] IDX_X     = 5'd23;
	localparam logic [4:0] IDX_LAST  = 5'd25;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CASE_DIFF = 8'h20;
	localparam logic [6:0] ASCII_A   = 7'h41;

	typedef enum logic [1:0] {
		OP_KEY      = 2'd0,
		OP_KEY_END  = 2'd1,
		OP_TEXT     = 2'd2,
		OP_TEXT_END = 2'd3
	} op_t;

	typedef logic [3:0] upc_t;

	localparam upc_t U_IDLE = 4'd0;
	localparam upc_t U_KEY  = 4'd1;
	localparam upc_t U_FILL = 4'd2;
	localparam upc_t U_TEXT = 4'd3;
	localparam upc_t U_TEND = 4'd4;
	localparam upc_t U_ENC0 = 4'd5;
	localparam upc_t U_ENC1 = 4'd6;
	localparam upc_t U_ENC2 = 4'd7;
	localparam upc_t U_ENC3 = 4'd8;
	localparam upc_t U_ENC4 = 4'd9;
	localparam upc_t U_ENC5 = 4'd10;

	typedef enum logic [3:0] {
		A_NONE,
		A_KEY,
		A_FILL,
		A_TEXT,
		A_TEND,
		A_RDA,
		A_RDB,
		A_CAPB,
		A_SQA,
		A_EMIT
	} act_t;

	typedef enum logic [2:0] {
		C_DISPATCH,
		C_NEXT,
		C_ENC,
		C_LOOP,
		C_OUTW
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  last;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] idx;
	} letter_t;

	typedef struct packed {
		logic [4:0] oa;
		logic [4:0] ob;
	} cell_pair_t;

	function automatic uword_t ucode(input upc_t upc);
		uword_t w;
		w = '{act: A_NONE, cond: C_DISPATCH, last: 1'b0, target: U_IDLE};
		case (upc)
			U_IDLE: w = '{act: A_NONE, cond: C_DISPATCH, last: 1'b0, target: U_IDLE};
			U_KEY:  w = '{act: A_KEY,  cond: C_ENC,      last: 1'b0, target: U_IDLE};
			U_FILL: w = '{act: A_FILL, cond: C_LOOP,     last: 1'b0, target: U_IDLE};
			U_TEXT: w = '{act: A_TEXT, cond: C_ENC,      last: 1'b0, target: U_ENC0};
			U_TEND: w = '{act: A_TEND, cond: C_ENC,      last: 1'b0, target: U_ENC0};
			U_ENC0: w = '{act: A_RDA,  cond: C_NEXT,     last: 1'b0, target: U_ENC1};
			U_ENC1: w = '{act: A_RDB,  cond: C_NEXT,     last: 1'b0, target: U_ENC2};
			U_ENC2: w = '{act: A_CAPB, cond: C_NEXT,     last: 1'b0, target: U_ENC3};
			U_ENC3: w = '{act: A_SQA,  cond: C_NEXT,     last: 1'b0, target: U_ENC4};
			U_ENC4: w = '{act: A_EMIT, cond: C_OUTW,     last: 1'b0, target: U_ENC5};
			U_ENC5: w = '{act: A_EMIT, cond: C_OUTW,     last: 1'b1, target: U_IDLE};
			default: w = '{act: A_NONE, cond: C_DISPATCH, last: 1'b0, target: U_IDLE};
		endcase
		return w;
	endfunction

	function automatic upc_t entry_of(input op_t op);
		upc_t u;
		case (op)
			OP_KEY:      u = U_KEY;
			OP_KEY_END:  u = U_FILL;
			OP_TEXT:     u = U_TEXT;
			OP_TEXT_END: u = U_TEND;
			default:     u = U_IDLE;
		endcase
		return u;
	endfunction

	// Fold case and drop Q and anything that is not a letter.
	function automatic letter_t letter_of(input logic [7:0] ch);
		letter_t    r;
		logic [7:0] c;
		logic [7:0] d;
		c = ch;
		if (c inside {[CH_LO_A:CH_LO_Z]}) begin
			c = c - CASE_DIFF;
		end
		d = c - CH_UP_A;
		r.idx = d[4:0];
		r.ok  = (c inside {[CH_UP_A:CH_UP_Z]}) && (d[4:0] != IDX_Q);
		return r;
	endfunction

	function automatic logic [2:0] row_of(input logic [4:0] p);
		logic [2:0] r;
		if (p >= 5'd20) begin
			r = 3'd4;
		end else if (p >= 5'd15) begin
			r = 3'd3;
		end else if (p >= 5'd10) begin
			r = 3'd2;
		end else if (p >= 5'd5) begin
			r = 3'd1;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic logic [4:0] times5(input logic [2:0] r);
		return {r, 2'b00} + {2'b00, r};
	endfunction

	function automatic logic [2:0] inc5(input logic [2:0] v);
		return (v == 3'd4) ? 3'd0 : v + 3'd1;
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
		return times5(r) + {2'b00, c};
	endfunction

	function automatic cell_pair_t encipher_cells(input logic [4:0] pa, input logic [4:0] pb);
		cell_pair_t res;
		logic [2:0] r1;
		logic [2:0] r2;
		logic [4:0] t1;
		logic [4:0] t2;
		logic [2:0] c1;
		logic [2:0] c2;
		r1 = row_of(pa);
		r2 = row_of(pb);
		t1 = pa - times5(r1);
		t2 = pb - times5(r2);
		c1 = t1[2:0];
		c2 = t2[2:0];
		if (c1 == c2) begin
			res.oa = cell_of(inc5(r1), c1);
			res.ob = cell_of(inc5(r2), c2);
		end else if (r1 == r2) begin
			res.oa = cell_of(r1, inc5(c1));
			res.ob = cell_of(r2, inc5(c2));
		end else begin
			res.oa = cell_of(r1, c2);
			res.ob = cell_of(r2, c1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pfe_stream_if.sv =====
// Valid/ready channel interfaces for plaintext items and cipher letters.
`default_nettype none
interface pfe_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] character;

	modport source(output valid, output operation, output character, input ready);
	modport sink(input valid, input operation, input character, output ready);
endinterface

interface pfe_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] cipher_letter;
	logic       last;

	modport source(output valid, output cipher_letter, output last, input ready);
	modport sink(input valid, input cipher_letter, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/playfair_encrypt.sv =====
// A digraph is emitted after the completing beat's text step, the reads of both letters' square positions,
// the square read of the first cipher cell and an emit step per letter, each held by an output stall.
// Key end runs a fill loop with one step per alphabet letter; no new item is taken until the block is idle.
// Step order is set by the single read port of the position and square memories.
// Reset clears the program counter, used-letter mask, fill count, pending and phase flags and
// the output valid; memory contents stay undefined until written.
`default_nettype none
module playfair_encrypt (
	input  logic         clk,
	input  logic         arst_n,
	pfe_item_if.sink     item,
	pfe_result_if.source result
);
	import pfe_pkg::*;

	upc_t   upc_q;
	upc_t   upc_nxt;
	uword_t uw;

	logic [4:0]  sq_mem [0:24];
	logic [4:0]  pos_mem [0:25];
	logic [4:0]  sq_rd_q;
	logic [4:0]  pos_rd_q;

	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic        text_phase_q;
	logic        pending_valid_q;
	logic [4:0]  pending_q;
	logic [4:0]  cnt_q;
	logic [4:0]  lt_q;
	logic        lt_ok_q;
	logic [4:0]  a_q;
	logic [4:0]  b_q;
	logic [4:0]  pa_q;
	logic [4:0]  pb_q;
	logic [4:0]  ob_q;
	logic        out_valid_q;
	logic [6:0]  out_letter_q;
	logic        out_last_q;

	logic        accept;
	logic        free;
	logic        need_enc;
	logic        emit_go;
	logic        app_clear;
	logic [25:0] used_base;
	logic [4:0]  fill_base;
	logic [4:0]  app_letter;
	logic        app_cand;
	logic        app_en;
	logic        sq_rd_en;
	logic [4:0]  sq_addr;
	logic [4:0]  pos_addr;
	logic [4:0]  pos_gated;
	logic        pos_used;
	cell_pair_t  cells;
	letter_t     dec;

	assign uw     = ucode(upc_q);
	assign accept = item.valid && item.ready;
	assign free   = !out_valid_q || result.ready;
	assign dec    = letter_of(item.character);

	assign item.ready           = (uw.cond == C_DISPATCH);
	assign result.valid         = out_valid_q;
	assign result.cipher_letter = out_letter_q;
	assign result.last          = out_last_q;

	assign need_enc = (uw.act == A_TEXT) ? (lt_ok_q && pending_valid_q) :
	                  (uw.act == A_TEND) ? pending_valid_q : 1'b0;
	assign emit_go  = (uw.act == A_EMIT) && free;

	// Append unit shared by key characters and the key-end fill loop.
	assign app_clear  = (uw.act == A_KEY) && text_phase_q;
	assign used_base  = app_clear ? '0 : used_q;
	assign fill_base  = app_clear ? '0 : fill_q;
	assign app_letter = (uw.act == A_FILL) ? cnt_q : lt_q;
	assign app_cand   = ((uw.act == A_KEY) && lt_ok_q) ||
	                    ((uw.act == A_FILL) && (cnt_q != IDX_Q));
	assign app_en     = app_cand && !used_base[app_letter] && (fill_base < CELLS);

	assign pos_addr  = (uw.act == A_RDA) ? a_q : b_q;
	assign pos_used  = (uw.act == A_RDB) ? used_q[a_q] : used_q[b_q];
	assign pos_gated = pos_used ? pos_rd_q : 5'd0;
	assign cells     = encipher_cells(pa_q, pb_q);
	assign sq_rd_en  = (uw.act == A_SQA) || emit_go;
	assign sq_addr   = (uw.act == A_SQA) ? cells.oa : ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	always_comb begin
		upc_nxt = upc_q;
		case (uw.cond)
			C_DISPATCH: upc_nxt = accept ? entry_of(op_t'(item.operation)) : U_IDLE;
			C_NEXT:     upc_nxt = upc_q + 4'd1;
			C_ENC:      upc_nxt = need_enc ? uw.target : U_IDLE;
			C_LOOP:     upc_nxt = (cnt_q == IDX_LAST) ? uw.target : upc_q;
			C_OUTW:     upc_nxt = free ? uw.target : upc_q;
			default:    upc_nxt = U_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (app_en) begin
			sq_mem[fill_base]   <= app_letter;
			pos_mem[app_letter] <= fill_base;
		end
		pos_rd_q <= pos_mem[pos_addr];
		if (sq_rd_en) begin
			sq_rd_q <= sq_mem[sq_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q          <= '0;
			fill_q          <= '0;
			text_phase_q    <= 1'b0;
			pending_valid_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if ((uw.act == A_KEY) || (uw.act == A_FILL)) begin
				used_q <= used_base | (app_en ? (26'd1 << app_letter) : 26'd0);
				fill_q <= fill_base + {4'd0, app_en};
			end
			if (app_clear) begin
				text_phase_q    <= 1'b0;
				pending_valid_q <= 1'b0;
			end
			if (uw.act == A_TEXT) begin
				text_phase_q <= 1'b1;
				if (lt_ok_q && !pending_valid_q) begin
					pending_valid_q <= 1'b1;
				end else if (lt_ok_q && (lt_q != pending_q)) begin
					pending_valid_q <= 1'b0;
				end
			end
			if (uw.act == A_TEND) begin
				text_phase_q    <= 1'b1;
				pending_valid_q <= 1'b0;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lt_q    <= dec.idx;
			lt_ok_q <= dec.ok;
			cnt_q   <= 5'd0;
		end
		if (uw.act == A_FILL) begin
			cnt_q <= cnt_q + 5'd1;
		end
		if ((uw.act == A_TEXT) && lt_ok_q) begin
			if (!pending_valid_q) begin
				pending_q <= lt_q;
			end else begin
				a_q <= pending_q;
				b_q <= (lt_q == pending_q) ? IDX_X : lt_q;
			end
		end
		if (uw.act == A_TEND) begin
			a_q <= pending_q;
			b_q <= IDX_X;
		end
		if (uw.act == A_RDB) begin
			pa_q <= pos_gated;
		end
		if (uw.act == A_CAPB) begin
			pb_q <= pos_gated;
		end
		if (uw.act == A_SQA) begin
			ob_q <= cells.ob;
		end
		if (emit_go) begin
			out_letter_q <= ASCII_A + {2'b00, sq_rd_q};
			out_last_q   <= uw.last;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pfe_checker.sv =====
// Port-level checks of the playfair encrypt block, bound to its top level.
`default_nettype none
`include "playfair_encrypt_assert.svh"
module pfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [6:0] result_cipher_letter,
	input logic       result_last
);
	// A stalled beat holds its payload.
	`PFE_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result_cipher_letter) && $stable(result_last))
	// The second letter of a digraph follows right behind the first.
	`PFE_ASSERT_NEXT(a_pair_follow, result_valid && result_ready && !result_last, result_valid && result_last)
	// No new item while a digraph is half delivered.
	`PFE_ASSERT_NOW(a_no_take_mid_pair, result_valid && result_ready && !result_last, !item_ready)
	// Drop ready in the cycle after taking an item.
	`PFE_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready)
endmodule

bind playfair_encrypt pfe_checker u_pfe_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.item_valid           (item.valid),
	.item_ready           (item.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_cipher_letter (result.cipher_letter),
	.result_last          (result.last)
);
`default_nettype wire

// ===== tb/tb_playfair_encrypt.sv =====
// Self-checking testbench for playfair_encrypt: directed rows, then random key/text sessions.
module tb_playfair_encrypt;
	import pfe_pkg::*;

	localparam int GRID_SIDE    = 5;
	localparam int GRID_CELLS   = 25;
	localparam int ALPHABET     = 26;
	localparam int ITEM_TARGET  = 800;
	localparam int MAX_IDLE     = 17;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} cipher_beat_t;

	typedef struct {
		op_t        op;
		logic [7:0] ch;
		bit         typed;
		logic [7:0] want_a;
		logic [7:0] want_b;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pfe_item_if   item_ch ();
	pfe_result_if res_ch ();

	playfair_encrypt i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// Shadow of the block's square and text state.
	logic [4:0]  grid [GRID_CELLS];
	logic [4:0]  cell_of_letter [ALPHABET];
	logic [25:0] placed;
	int unsigned filled;
	bit          held_v;
	logic [4:0]  held;
	bit          in_text;

	cipher_beat_t cipher_due [$];
	int           errors = 0;
	int           items_done;
	int           cycle_count = 0;
	int           src_mode;
	int           snk_mode;
	bit           keyed_once;

	// Square fixed by an empty key: A..Z without Q, row by row.
	stim_row_t plan [27] = '{
		'{OP_KEY_END,  8'h00, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "A",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "b",   1'b1, "B",   "C"  },
		'{OP_TEXT,     "Z",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT_END, 8'h00, 1'b1, "V",   "Y"  },
		'{OP_TEXT,     "a",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "A",   1'b1, "C",   "V"  },
		'{OP_TEXT,     "Q",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     8'h00, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     8'hFF, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     " ",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT_END, 8'hFF, 1'b1, "C",   "V"  },
		'{OP_TEXT_END, 8'hAA, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "X",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "x",   1'b1, "C",   "C"  },
		'{OP_TEXT_END, 8'h55, 1'b1, "C",   "C"  },
		'{OP_KEY,      "P",   1'b0, 8'h00, 8'h00},
		'{OP_KEY,      " ",   1'b0, 8'h00, 8'h00},
		'{OP_KEY,      "l",   1'b0, 8'h00, 8'h00},
		'{OP_KEY,      "q",   1'b0, 8'h00, 8'h00},
		'{OP_KEY,      8'h80, 1'b0, 8'h00, 8'h00},
		'{OP_KEY,      "P",   1'b0, 8'h00, 8'h00},
		'{OP_KEY_END,  8'hFF, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "H",   1'b0, 8'h00, 8'h00},
		'{OP_KEY_END,  8'h00, 1'b0, 8'h00, 8'h00},
		'{OP_TEXT,     "i",   1'b0, 8'h00, 8'h00},
		'{OP_TEXT_END, 8'h00, 1'b0, 8'h00, 8'h00}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Fold case; drop Q and anything that is not a letter.
	function automatic bit fold_letter(input logic [7:0] ch, output logic [4:0] li);
		logic [7:0] c;
		logic [7:0] d;
		c = ch;
		if (c >= "a" && c <= "z") begin
			c = c - 8'h20;
		end
		d = c - "A";
		li = d[4:0];
		return (c >= "A") && (c <= "Z") && (d[4:0] != IDX_Q);
	endfunction

	function automatic void place_letter(input logic [4:0] li);
		if (placed[li] || filled >= GRID_CELLS) begin
			return;
		end
		grid[filled] = li;
		cell_of_letter[li] = 5'(filled);
		placed[li] = 1'b1;
		filled++;
	endfunction

	function automatic int unsigned cell_for(input logic [4:0] li);
		return placed[li] ? int'(cell_of_letter[li]) : 0;
	endfunction

	function automatic void encipher_pair(input logic [4:0] a, input logic [4:0] b,
			output cipher_beat_t x, output cipher_beat_t y);
		int unsigned pa;
		int unsigned pb;
		int unsigned r1;
		int unsigned c1;
		int unsigned r2;
		int unsigned c2;
		int unsigned oa;
		int unsigned ob;
		pa = cell_for(a);
		pb = cell_for(b);
		r1 = pa / GRID_SIDE;
		c1 = pa % GRID_SIDE;
		r2 = pb / GRID_SIDE;
		c2 = pb % GRID_SIDE;
		if (c1 == c2) begin
			oa = ((r1 + 1) % GRID_SIDE) * GRID_SIDE + c1;
			ob = ((r2 + 1) % GRID_SIDE) * GRID_SIDE + c2;
		end else if (r1 == r2) begin
			oa = r1 * GRID_SIDE + (c1 + 1) % GRID_SIDE;
			ob = r2 * GRID_SIDE + (c2 + 1) % GRID_SIDE;
		end else begin
			oa = r1 * GRID_SIDE + c2;
			ob = r2 * GRID_SIDE + c1;
		end
		x.letter = ASCII_A + 7'(grid[oa]);
		x.last   = 1'b0;
		y.letter = ASCII_A + 7'(grid[ob]);
		y.last   = 1'b1;
	endfunction

	// Advance the shadow state by one item; return how many cipher beats it yields.
	function automatic int playfair_step(input op_t op, input logic [7:0] ch,
			output cipher_beat_t x, output cipher_beat_t y);
		logic [4:0] li;
		bit         ok;
		x = '0;
		y = '0;
		ok = fold_letter(ch, li);
		case (op)
			OP_KEY: begin
				if (in_text) begin
					placed  = '0;
					filled  = 0;
					held_v  = 1'b0;
					held    = '0;
					in_text = 1'b0;
				end
				if (ok) begin
					place_letter(li);
				end
				return 0;
			end
			OP_KEY_END: begin
				for (int i = 0; i < ALPHABET; i++) begin
					if (5'(i) != IDX_Q) begin
						place_letter(5'(i));
					end
				end
				return 0;
			end
			OP_TEXT: begin
				in_text = 1'b1;
				if (!ok) begin
					return 0;
				end
				if (!held_v) begin
					held_v = 1'b1;
					held   = li;
					return 0;
				end
				if (li == held) begin
					// doubled letter: pair with X and keep it waiting
					encipher_pair(held, IDX_X, x, y);
					return 2;
				end
				encipher_pair(held, li, x, y);
				held_v = 1'b0;
				held   = '0;
				return 2;
			end
			default: begin
				in_text = 1'b1;
				if (!held_v) begin
					return 0;
				end
				encipher_pair(held, IDX_X, x, y);
				held_v = 1'b0;
				held   = '0;
				return 2;
			end
		endcase
	endfunction

	function automatic int idle_cycles(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, MAX_IDLE);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
		endcase
	endfunction

	function automatic logic [7:0] random_letter();
		int k;
		k = $urandom_range(0, 24);
		if (k >= int'(IDX_Q)) begin
			k++;
		end
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(k);
	endfunction

	task automatic send_item(input op_t op, input logic [7:0] ch, input bit typed,
			input logic [7:0] want_a, input logic [7:0] want_b);
		int           gap;
		int           n;
		cipher_beat_t x;
		cipher_beat_t y;
		logic [4:0]   li;
		gap = idle_cycles(src_mode);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.operation = op;
		item_ch.character = ch;
		item_ch.valid     = 1'b1;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		n = playfair_step(op, ch, x, y);
		if (typed) begin
			x.letter = want_a[6:0];
			y.letter = want_b[6:0];
		end
		if (n == 2) begin
			cipher_due.push_back(x);
			cipher_due.push_back(y);
		end
		if (op inside {OP_KEY_END, OP_TEXT_END} || fold_letter(ch, li)) begin
			items_done++;
		end
		@(negedge clk);
	endtask

	task automatic send(input op_t op, input logic [7:0] ch);
		send_item(op, ch, 1'b0, 8'h00, 8'h00);
	endtask

	// One key followed by one stretch of text, mostly well formed.
	task automatic run_session();
		int         key_len;
		int         text_len;
		int         r;
		logic [7:0] prev;
		prev = "E";
		src_mode = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0: key_len = 0;
			1: key_len = $urandom_range(26, 32);
			default: key_len = $urandom_range(1, 10);
		endcase
		for (int i = 0; i < key_len; i++) begin
			case ($urandom_range(0, 7))
				0: send(OP_KEY, " ");
				1: send(OP_KEY, 8'($urandom_range(0, 255)));
				2: send(OP_KEY, $urandom_range(0, 1) ? "Q" : "q");
				default: send(OP_KEY, random_letter());
			endcase
		end
		// Leave the square partial now and then so text hits letters not yet placed.
		if (!keyed_once || $urandom_range(0, 7) != 0) begin
			send(OP_KEY_END, 8'($urandom_range(0, 255)));
			keyed_once = 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				send(OP_KEY_END, 8'($urandom_range(0, 255)));
			end
		end
		text_len = $urandom_range(0, 18);
		for (int i = 0; i < text_len; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				send(OP_TEXT, 8'($urandom_range(0, 255)));
			end else if (r == 1) begin
				send(OP_TEXT, prev ^ 8'h20);
			end else if (r == 2 && $urandom_range(0, 3) == 0) begin
				send(OP_KEY_END, 8'($urandom_range(0, 255)));
			end else if (r == 3) begin
				prev = $urandom_range(0, 1) ? "X" : "x";
				send(OP_TEXT, prev);
			end else begin
				prev = random_letter();
				send(OP_TEXT, prev);
			end
		end
		if ($urandom_range(0, 6) != 0) begin
			send(OP_TEXT_END, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		items_done        = 0;
		keyed_once        = 1'b0;
		src_mode          = 1;
		placed            = '0;
		filled            = 0;
		held_v            = 1'b0;
		held              = '0;
		in_text           = 1'b0;
		foreach (grid[i]) grid[i] = '0;
		foreach (cell_of_letter[i]) cell_of_letter[i] = '0;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_KEY;
		item_ch.character = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (plan[i]) begin
			send_item(plan[i].op, plan[i].ch, plan[i].typed, plan[i].want_a, plan[i].want_b);
		end
		keyed_once = 1'b1;
		while (items_done < ITEM_TARGET) begin
			run_session();
		end
		item_ch.valid = 1'b0;
		while (cipher_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Result sink: stall at random, check each beat against the oldest expectation.
	initial begin
		int           stall;
		int           beats;
		cipher_beat_t want;
		beats        = 0;
		snk_mode     = 1;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (beats % 32 == 0) begin
				snk_mode = $urandom_range(0, 2);
			end
			stall = idle_cycles(snk_mode);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			beats++;
			if (cipher_due.size() == 0) begin
				errors++;
				$display("%0t: cipher beat with nothing expected: got %c last %b",
					$time, res_ch.cipher_letter, res_ch.last);
			end else begin
				want = cipher_due.pop_front();
				if (res_ch.cipher_letter !== want.letter || res_ch.last !== want.last) begin
					errors++;
					$display("%0t: cipher beat mismatch: expected %c last %b, got %c last %b",
						$time, want.letter, want.last, res_ch.cipher_letter, res_ch.last);
				end
			end
			@(negedge clk);
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfe_pkg.sv
rtl/pfe_stream_if.sv
rtl/playfair_encrypt.sv
rtl/pfe_checker.sv
tb/tb_playfair_encrypt.sv
